>>> sv/i2r_pkg.sv
// Package: types, constants and control store for the integer to Roman numeral converter.
package i2r_pkg;

  localparam int unsigned MaxValue = 3999;
  localparam int unsigned ValW     = 12;
  localparam int unsigned PcW      = 4;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_DIV,
    OP_EMIT,
    OP_ERR
  } op_e;

  typedef struct packed {
    op_e            op;
    logic [1:0]     pos;
    logic [PcW-1:0] nxt;
  } uword_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic [2:0] len;
  } letter_t;

  localparam logic [PcW-1:0] StepIdle = 4'd0;
  localparam logic [PcW-1:0] StepErr  = 4'd9;

  // powers of ten, indexed by digit position
  localparam logic [ValW-1:0] Divisor [4] = '{12'd1, 12'd10, 12'd100, 12'd1000};

  localparam logic [7:0] OneLetter  [4] = '{"I", "X", "C", "M"};
  localparam logic [7:0] FiveLetter [4] = '{"V", "L", "D", 8'h00};
  localparam logic [7:0] TenLetter  [4] = '{"X", "C", "M", 8'h00};

  localparam logic [2:0] DigitLen [10] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd2,
                                           3'd1, 3'd2, 3'd3, 3'd4, 3'd2};
  // two bits per letter: 0 one, 1 five, 2 ten
  localparam logic [7:0] DigitPat [10] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h04,
                                           8'h01, 8'h01, 8'h01, 8'h01, 8'h08};

  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_WAIT, pos: 2'd0, nxt: 4'd1};
      4'd1:    w = '{op: OP_DIV,  pos: 2'd3, nxt: 4'd2};
      4'd2:    w = '{op: OP_DIV,  pos: 2'd2, nxt: 4'd3};
      4'd3:    w = '{op: OP_DIV,  pos: 2'd1, nxt: 4'd4};
      4'd4:    w = '{op: OP_DIV,  pos: 2'd0, nxt: 4'd5};
      4'd5:    w = '{op: OP_EMIT, pos: 2'd3, nxt: 4'd6};
      4'd6:    w = '{op: OP_EMIT, pos: 2'd2, nxt: 4'd7};
      4'd7:    w = '{op: OP_EMIT, pos: 2'd1, nxt: 4'd8};
      4'd8:    w = '{op: OP_EMIT, pos: 2'd0, nxt: StepIdle};
      4'd9:    w = '{op: OP_ERR,  pos: 2'd0, nxt: StepIdle};
      default: w = '{op: OP_WAIT, pos: 2'd0, nxt: StepIdle};
    endcase
    return w;
  endfunction

endpackage

>>> sv/i2r_letter.sv
// Letter lookup: digit, position and letter index to ASCII symbol and pattern length.
module i2r_letter (
  input  logic [1:0]       pos_i,
  input  logic [3:0]       digit_i,
  input  logic [1:0]       idx_i,
  output i2r_pkg::letter_t letter_o
);

  logic [7:0] pat;
  logic [1:0] sel;

  always_comb begin
    if (digit_i <= 4'd9) begin
      pat          = i2r_pkg::DigitPat[digit_i];
      letter_o.len = i2r_pkg::DigitLen[digit_i];
    end else begin
      pat          = 8'h00;
      letter_o.len = 3'd0;
    end
    sel = pat[{idx_i, 1'b0} +: 2];
    case (sel)
      2'd1:    letter_o.symbol = i2r_pkg::FiveLetter[pos_i];
      2'd2:    letter_o.symbol = i2r_pkg::TenLetter[pos_i];
      default: letter_o.symbol = i2r_pkg::OneLetter[pos_i];
    endcase
  end

endmodule

>>> sv/integer_to_roman_numeral.sv
// Top level: microcoded integer to Roman numeral converter.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------
//  command | in        | start_i high, busy_o low | value_i
//  result  | out       | strobe_o, one cycle      | symbol_o, last_o, too_large_o
//
// One item: the accept step, then repeated subtraction for each digit position, thousands first,
// then the emit steps that send each position's letters, in the same order.
// Values above 3999 give one error result.
// The step counter and its control word set the pace; at most one letter leaves per cycle.
// Reset clears the step counter, the letter index and the result strobe. Results cannot be held off.
module integer_to_roman_numeral (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] value_i,
  output logic        busy_o,
  output logic        strobe_o,
  output logic [7:0]  symbol_o,
  output logic        last_o,
  output logic        too_large_o
);

  logic [i2r_pkg::PcW-1:0]  pc_q, pc_d;
  logic [i2r_pkg::ValW-1:0] v_q, v_d;
  logic [3:0]               dig_q [4];
  logic [3:0]               dig_d [4];
  logic [1:0]               k_q, k_d;
  logic                     strobe_q, strobe_d;
  logic [7:0]               symbol_q, symbol_d;
  logic                     last_q, last_d, too_large_q, too_large_d;
  i2r_pkg::uword_t          uw;
  i2r_pkg::letter_t         letter;
  logic                     lower_zero;
  logic                     end_of_digit;

  assign uw = i2r_pkg::ucode(pc_q);

  i2r_letter u_letter (
    .pos_i    (uw.pos),
    .digit_i  (dig_q[uw.pos]),
    .idx_i    (k_q),
    .letter_o (letter)
  );

  always_comb begin
    lower_zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (i < int'(uw.pos) && dig_q[i] != 4'd0) begin
        lower_zero = 1'b0;
      end
    end
  end

  assign end_of_digit = ({1'b0, k_q} == letter.len - 3'd1);

  always_comb begin
    pc_d        = pc_q;
    v_d         = v_q;
    dig_d       = dig_q;
    k_d         = k_q;
    strobe_d    = 1'b0;
    symbol_d    = symbol_q;
    last_d      = last_q;
    too_large_d = too_large_q;
    case (uw.op)
      i2r_pkg::OP_WAIT: begin
        if (start_i) begin
          v_d   = value_i[i2r_pkg::ValW-1:0];
          dig_d = '{default: 4'd0};
          k_d   = 2'd0;
          if (value_i > 16'(i2r_pkg::MaxValue)) begin
            pc_d = i2r_pkg::StepErr;
          end else if (value_i != 16'd0) begin
            pc_d = uw.nxt;
          end
        end
      end
      i2r_pkg::OP_DIV: begin
        if (v_q >= i2r_pkg::Divisor[uw.pos]) begin
          v_d            = v_q - i2r_pkg::Divisor[uw.pos];
          dig_d[uw.pos]  = dig_q[uw.pos] + 4'd1;
        end else begin
          pc_d = uw.nxt;
        end
      end
      i2r_pkg::OP_EMIT: begin
        if (letter.len == 3'd0) begin
          k_d  = 2'd0;
          pc_d = uw.nxt;
        end else begin
          strobe_d    = 1'b1;
          symbol_d    = letter.symbol;
          last_d      = end_of_digit && lower_zero;
          too_large_d = 1'b0;
          if (end_of_digit) begin
            k_d  = 2'd0;
            pc_d = uw.nxt;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
      end
      i2r_pkg::OP_ERR: begin
        strobe_d    = 1'b1;
        symbol_d    = 8'h00;
        last_d      = 1'b1;
        too_large_d = 1'b1;
        pc_d        = uw.nxt;
      end
      default: pc_d = i2r_pkg::StepIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= i2r_pkg::StepIdle;
      k_q      <= 2'd0;
      strobe_q <= 1'b0;
    end else begin
      pc_q     <= pc_d;
      k_q      <= k_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q         <= v_d;
    dig_q       <= dig_d;
    symbol_q    <= symbol_d;
    last_q      <= last_d;
    too_large_q <= too_large_d;
  end

  assign busy_o      = (uw.op != i2r_pkg::OP_WAIT);
  assign strobe_o    = strobe_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;
  assign too_large_o = too_large_q;

endmodule

>>> tb/sv/integer_to_roman_numeral_test.sv
// Self-checking testbench for the integer to Roman numeral converter.
`timescale 1ns / 100ps

typedef struct packed {
  logic [7:0] symbol;
  logic       last;
  logic       too_large;
} numeral_out_t;

class numeral_scoreboard;
  numeral_out_t letters_due[$];
  logic [7:0]   spelt[$];
  int unsigned  mismatches;
  int unsigned  values_seen;
  int unsigned  letters_total;
  int unsigned  too_large_total;
  int unsigned  zeros_seen;

  function void report(string what, numeral_out_t want, numeral_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected symbol %h last %b too_large %b,",
               $time, what, want.symbol, want.last, want.too_large);
      $display("    got symbol %h last %b too_large %b",
               got.symbol, got.last, got.too_large);
    end
  endfunction

  // one decimal digit in subtractive form
  function void spell_digit(int unsigned d, logic [7:0] one, logic [7:0] five, logic [7:0] ten);
    case (d)
      1, 2, 3: begin
        repeat (d) spelt.push_back(one);
      end
      4: begin
        spelt.push_back(one);
        spelt.push_back(five);
      end
      5, 6, 7, 8: begin
        spelt.push_back(five);
        repeat (d - 5) spelt.push_back(one);
      end
      9: begin
        spelt.push_back(one);
        spelt.push_back(ten);
      end
      default: begin
      end
    endcase
  endfunction

  function void note_value(logic [15:0] value);
    int unsigned  rest;
    numeral_out_t r;
    values_seen++;
    if (value > i2r_pkg::MaxValue) begin
      r = '{symbol: 8'h00, last: 1'b1, too_large: 1'b1};
      letters_due.push_back(r);
      too_large_total++;
    end else begin
      spelt.delete();
      rest = {16'd0, value};
      repeat (rest / 1000) spelt.push_back("M");
      rest = rest % 1000;
      spell_digit(rest / 100, "C", "D", "M");
      rest = rest % 100;
      spell_digit(rest / 10, "X", "L", "C");
      spell_digit(rest % 10, "I", "V", "X");
      if (spelt.size() == 0) zeros_seen++;
      foreach (spelt[k]) begin
        r.symbol    = spelt[k];
        r.last      = (k == spelt.size() - 1);
        r.too_large = 1'b0;
        letters_due.push_back(r);
      end
      letters_total += spelt.size();
    end
  endfunction

  function void check_result(logic [7:0] symbol, logic last, logic too_large);
    numeral_out_t want;
    numeral_out_t got;
    got = '{symbol: symbol, last: last, too_large: too_large};
    if (letters_due.size() == 0) begin
      report("result with nothing pending", '0, got);
    end else begin
      want = letters_due.pop_front();
      if (got !== want) report("mismatch", want, got);
    end
  endfunction
endclass

module integer_to_roman_numeral_test;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [15:0] value_i = '0;
  logic        busy_o;
  logic        strobe_o;
  logic [7:0]  symbol_o;
  logic        last_o;
  logic        too_large_o;

  numeral_scoreboard numerals = new();
  int unsigned       quiet_cycles = 0;

  integer_to_roman_numeral dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .strobe_o    (strobe_o),
    .symbol_o    (symbol_o),
    .last_o      (last_o),
    .too_large_o (too_large_o)
  );

  always #10 clk_i = ~clk_i;

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) numerals.note_value(value_i);
      if (strobe_o) numerals.check_result(symbol_o, last_o, too_large_o);
      if ((start_i && !busy_o) || strobe_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("** integer_to_roman_numeral: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // called just after a rising edge; returns just after the accepting edge
  task automatic drive_value(input logic [15:0] v, input int unsigned gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
  endtask

  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    int unsigned heavy;
    case ($urandom_range(0, 19))
      0: v = '0;
      1, 2: v = 16'($urandom_range(i2r_pkg::MaxValue + 1, 65535));
      3: v = 16'($urandom());
      4, 5: begin
        // long numerals: digits drawn from the heavy end
        heavy = $urandom_range(0, 3) * 1000
                + ($urandom_range(0, 1) ? 8 : $urandom_range(3, 9)) * 100
                + ($urandom_range(0, 1) ? 8 : $urandom_range(3, 9)) * 10
                + ($urandom_range(0, 1) ? 8 : $urandom_range(3, 9));
        v = heavy[15:0];
      end
      default: v = 16'($urandom_range(1, i2r_pkg::MaxValue));
    endcase
    return v;
  endfunction

  initial begin
    logic [15:0] directed [$];
    bit          idle_free;
    int unsigned gap;
    directed = '{16'd0, 16'd1, 16'd4, 16'd5, 16'd9, 16'd10, 16'd40, 16'd49, 16'd90,
                 16'd99, 16'd400, 16'd444, 16'd500, 16'd900, 16'd999, 16'd1000,
                 16'd3888, 16'd3999, 16'd4000, 16'd65535, 16'h8000, 16'd2741,
                 16'd1666, 16'd0, 16'd3888};
    idle_free = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) drive_value(directed[i], (i % 3 == 0) ? 0 : $urandom_range(0, 17));

    for (int n = 0; n < 310; n++) begin
      if (n % 40 == 0) idle_free = ($urandom_range(0, 3) == 0);
      if (n == 150) begin
        // let the block drain completely before going on
        start_i <= 1'b0;
        @(posedge clk_i);
        while (numerals.letters_due.size() != 0) @(posedge clk_i);
      end
      gap = idle_free ? 0 : $urandom_range(0, 17);
      drive_value(pick_value(), gap);
    end
    start_i <= 1'b0;

    while (numerals.letters_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (numerals.letters_due.size() != 0) begin
      $display("%0d results never arrived", numerals.letters_due.size());
      numerals.mismatches += numerals.letters_due.size();
    end
    $display("Converted %0d values (%0d zero, %0d over range) into %0d letters.",
             numerals.values_seen, numerals.zeros_seen, numerals.too_large_total,
             numerals.letters_total);
    $display("Failures counted: %0d", numerals.mismatches);
    if (numerals.mismatches == 0) begin
      $display("** integer_to_roman_numeral: PASSED **");
    end else begin
      $display("** integer_to_roman_numeral: FAILED **");
    end
    $finish;
  end

endmodule
